// ===== rtl/core/mbg_pkg.sv =====
// Shared types, codes and constants of the maze backtracker generator.
package mbg_pkg;

  localparam int unsigned MAX_DIM_DEF = 64;

  localparam int unsigned COORD_W   = 6;
  localparam int unsigned DIM_REG_W = 7;
  localparam int unsigned SEED_W    = 16;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned IN_DAT_W  = 16;
  localparam int unsigned OUT_DAT_W = 16;

  localparam logic [DIM_REG_W-1:0] GRID_WIDTH_RST  = 7'd21;
  localparam logic [DIM_REG_W-1:0] GRID_HEIGHT_RST = 7'd21;
  localparam logic [SEED_W-1:0]    RNG_SEED_RST    = 16'd44257;
  localparam logic [SEED_W-1:0]    LFSR_TAPS       = 16'hB400;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED    = 2'd2;

  localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  localparam logic [3:0] DIRS_ALL = 4'hF;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] dirs;
    logic       linked;
    logic [1:0] parent;
  } cell_t;

  typedef struct packed {
    logic cap_in;
    logic sweep_wr;
    logic start_walk;
    logic rd_cur;
    logic rd_tgt;
    logic rd_req;
    logic load_cur;
    logic draw;
    logic wr_tgt;
    logic wr_mid;
    logic wr_cur;
    logic wr_start;
    logic move_tgt;
    logic move_parent;
    logic set_done;
    logic val_wall;
    logic val_mem;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic gen_done;
    logic rd_ok;
    logic dirs_zero;
    logic hit;
    logic tgt_ok;
    logic tgt_free;
    logic at_start;
    logic start_next;
    logic out_full;
  } sts_t;

endpackage

// ===== rtl/core/maze_backtracker_generator.sv =====
// Top level of the maze generator: stream ports, configuration port, controller and datapath.
//
//   Channel   Direction  Handshake                    Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  op, row, col
//   m_axis    out        m_axis_tvalid/m_axis_tready  at_col, at_row, finished, cell_value
//   cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Every input transfer gives exactly one output transfer. The grid store has one read and
// one write port. A step draws from the LFSR until it hits an untried direction in the grid
// and reads that target, drawing again if it is taken; once the walk has ended it changes
// nothing. A read fetches the requested cell; a restart sweeps the store one cell a cycle.
// Reset needs no clearing pass: until the first restart reads return wall and steps do
// nothing. The result sits in an output register, so a new item is taken while the previous
// result waits; cfg is always ready.
module maze_backtracker_generator #(
  parameter int unsigned MAX_DIM = mbg_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // op [1:0], row [7:2], col [13:8], zero [15:14]
  input  logic [mbg_pkg::IN_DAT_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // at_col [5:0], at_row [11:6], finished [12], cell_value [14:13], zero [15]
  output logic [mbg_pkg::OUT_DAT_W-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mbg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mbg_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import mbg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [OP_W-1:0]    in_op;
  logic [COORD_W-1:0] in_row, in_col;

  assign in_op  = s_axis_tdata[OP_W-1:0];
  assign in_row = s_axis_tdata[OP_W+COORD_W-1:OP_W];
  assign in_col = s_axis_tdata[OP_W+2*COORD_W-1:OP_W+COORD_W];

  assign cfg_ready_o = 1'b1;

  mbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (in_op),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .m_ready_i  (m_axis_tready),
    .cmd_o      (cmd)
  );

  mbg_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_row_i    (in_row),
    .in_col_i    (in_col),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata)
  );

endmodule

// ===== rtl/core/mbg_datapath.sv =====
// Datapath of the maze generator: grid store, walk position, LFSR and result register.
module mbg_datapath #(
  parameter int unsigned MAX_DIM = mbg_pkg::MAX_DIM_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [mbg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mbg_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  input  logic [mbg_pkg::COORD_W-1:0]         in_row_i,
  input  logic [mbg_pkg::COORD_W-1:0]         in_col_i,
  input  mbg_pkg::cmd_t                       cmd_i,
  output mbg_pkg::sts_t                       sts_o,
  input  logic                                m_ready_i,
  output logic                                m_valid_o,
  output logic [mbg_pkg::OUT_DAT_W-1:0]       m_data_o
);
  import mbg_pkg::*;

  localparam int unsigned CW     = $clog2(MAX_DIM);
  localparam int unsigned AW     = 2 * CW;
  localparam int unsigned Depth  = 1 << AW;
  localparam int unsigned DimLim = 1 << DIM_REG_W;
  localparam int unsigned CmpW   = ((CW + 1 > DIM_REG_W) ? CW + 1 : DIM_REG_W) + 1;
  localparam int unsigned PadW   = OUT_DAT_W - (2 * COORD_W + 3);

  logic [DIM_REG_W-1:0] width_q, height_q;
  logic [SEED_W-1:0]    seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= GRID_WIDTH_RST;
      height_q <= GRID_HEIGHT_RST;
      seed_q   <= RNG_SEED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH:  width_q  <= cfg_data_i[DIM_REG_W-1:0];
        CFG_GRID_HEIGHT: height_q <= cfg_data_i[DIM_REG_W-1:0];
        CFG_RNG_SEED:    seed_q   <= cfg_data_i[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_REG_W-1:0] w_eff, h_eff;
  logic [CmpW-1:0]      w_ext, h_ext;

  assign w_eff = (MAX_DIM < DimLim && width_q > DIM_REG_W'(MAX_DIM)) ?
                 DIM_REG_W'(MAX_DIM) : width_q;
  assign h_eff = (MAX_DIM < DimLim && height_q > DIM_REG_W'(MAX_DIM)) ?
                 DIM_REG_W'(MAX_DIM) : height_q;
  assign w_ext = CmpW'(w_eff);
  assign h_ext = CmpW'(h_eff);

  logic [CW-1:0]      pos_col_q, pos_row_q;
  logic [SEED_W-1:0]  rng_q;
  logic               gen_done_q, init_q;
  logic [AW-1:0]      cnt_q;
  logic [COORD_W-1:0] req_row_q, req_col_q;
  logic [3:0]         dirs_q;
  logic [1:0]         cur_kind_q, cur_parent_q, d_q;
  logic               cur_linked_q;
  logic [CW-1:0]      tgt_col_q, tgt_row_q;
  logic [1:0]         value_q;
  cell_t              rdata_q;

  logic [SEED_W-1:0] lfsr_nxt;
  logic [1:0]        d_new;
  logic [CmpW-1:0]   col_p2, row_p2;
  logic              tgt_ok;
  logic [CW-1:0]     tc_new, tr_new;

  assign lfsr_nxt = (rng_q >> 1) ^ (rng_q[0] ? LFSR_TAPS : '0);
  assign d_new    = lfsr_nxt[1:0];
  assign col_p2   = CmpW'(pos_col_q) + CmpW'(2);
  assign row_p2   = CmpW'(pos_row_q) + CmpW'(2);

  always_comb begin
    tc_new = pos_col_q;
    tr_new = pos_row_q;
    tgt_ok = 1'b0;
    case (d_new)
      DIR_RIGHT: begin
        tgt_ok = col_p2 < w_ext;
        tc_new = CW'(col_p2);
      end
      DIR_DOWN: begin
        tgt_ok = row_p2 < h_ext;
        tr_new = CW'(row_p2);
      end
      DIR_LEFT: begin
        tgt_ok = pos_col_q >= CW'(2);
        tc_new = pos_col_q - CW'(2);
      end
      default: begin
        tgt_ok = pos_row_q >= CW'(2);
        tr_new = pos_row_q - CW'(2);
      end
    endcase
  end

  logic [CW-1:0] mid_col, mid_row, par_col, par_row;

  always_comb begin
    mid_col = pos_col_q;
    mid_row = pos_row_q;
    case (d_q)
      DIR_RIGHT: mid_col = pos_col_q + CW'(1);
      DIR_DOWN:  mid_row = pos_row_q + CW'(1);
      DIR_LEFT:  mid_col = pos_col_q - CW'(1);
      default:   mid_row = pos_row_q - CW'(1);
    endcase
  end

  always_comb begin
    par_col = pos_col_q;
    par_row = pos_row_q;
    case (cur_parent_q)
      DIR_RIGHT: par_col = pos_col_q + CW'(2);
      DIR_DOWN:  par_row = pos_row_q + CW'(2);
      DIR_LEFT:  par_col = pos_col_q - CW'(2);
      default:   par_row = pos_row_q - CW'(2);
    endcase
  end

  logic [CW-1:0] sw_row, sw_col;
  logic          sw_open;

  assign sw_row  = cnt_q[AW-1:CW];
  assign sw_col  = cnt_q[CW-1:0];
  assign sw_open = (CmpW'(sw_row) < h_ext) && (CmpW'(sw_col) < w_ext) &&
                   sw_row[0] && sw_col[0];

  cell_t         mem [Depth];
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  cell_t         wdata;

  always_comb begin
    we    = 1'b1;
    waddr = {pos_row_q, pos_col_q};
    wdata = '{kind: cur_kind_q, dirs: dirs_q, linked: cur_linked_q, parent: cur_parent_q};
    if (cmd_i.sweep_wr) begin
      waddr = cnt_q;
      wdata = '{kind: sw_open ? KIND_OPEN : KIND_WALL, dirs: sw_open ? DIRS_ALL : 4'd0,
                linked: (sw_row == CW'(1)) && (sw_col == CW'(1)), parent: DIR_RIGHT};
    end else if (cmd_i.wr_tgt) begin
      waddr = {tgt_row_q, tgt_col_q};
      wdata = '{kind: rdata_q.kind, dirs: rdata_q.dirs, linked: 1'b1,
                parent: d_q ^ DIR_LEFT};
    end else if (cmd_i.wr_mid) begin
      waddr = {mid_row, mid_col};
      wdata = '{kind: KIND_OPEN, dirs: 4'd0, linked: 1'b0, parent: DIR_RIGHT};
    end else if (cmd_i.wr_start) begin
      waddr = {CW'(1), CW'(1)};
      wdata = '{kind: KIND_START, dirs: 4'd0, linked: 1'b1, parent: DIR_RIGHT};
    end else if (!cmd_i.wr_cur) begin
      we = 1'b0;
    end
  end

  always_comb begin
    re    = cmd_i.rd_cur | cmd_i.rd_tgt | cmd_i.rd_req;
    raddr = {pos_row_q, pos_col_q};
    if (cmd_i.rd_tgt) begin
      raddr = {tgt_row_q, tgt_col_q};
    end else if (cmd_i.rd_req) begin
      raddr = {CW'(req_row_q), CW'(req_col_q)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_col_q  <= CW'(1);
      pos_row_q  <= CW'(1);
      rng_q      <= RNG_SEED_RST;
      gen_done_q <= 1'b1;
      init_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (cmd_i.cap_in) begin
        cnt_q <= '0;
      end else if (cmd_i.sweep_wr) begin
        cnt_q <= cnt_q + AW'(1);
      end
      if (cmd_i.start_walk) begin
        pos_col_q  <= CW'(1);
        pos_row_q  <= CW'(1);
        rng_q      <= (seed_q == '0) ? SEED_W'(1) : seed_q;
        gen_done_q <= 1'b0;
        init_q     <= 1'b1;
      end
      if (cmd_i.draw) begin
        rng_q <= lfsr_nxt;
      end
      if (cmd_i.move_tgt) begin
        pos_col_q <= tgt_col_q;
        pos_row_q <= tgt_row_q;
      end
      if (cmd_i.move_parent) begin
        pos_col_q <= par_col;
        pos_row_q <= par_row;
      end
      if (cmd_i.set_done) begin
        gen_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      req_row_q <= in_row_i;
      req_col_q <= in_col_i;
    end
    if (cmd_i.load_cur) begin
      dirs_q       <= rdata_q.dirs;
      cur_kind_q   <= rdata_q.kind;
      cur_linked_q <= rdata_q.linked;
      cur_parent_q <= rdata_q.parent;
    end else if (cmd_i.draw && dirs_q[d_new]) begin
      dirs_q    <= dirs_q & ~(4'b0001 << d_new);
      d_q       <= d_new;
      tgt_col_q <= tc_new;
      tgt_row_q <= tr_new;
    end
    if (cmd_i.cap_in) begin
      value_q <= KIND_OPEN;
    end else if (cmd_i.val_wall) begin
      value_q <= KIND_WALL;
    end else if (cmd_i.val_mem) begin
      value_q <= rdata_q.kind;
    end
  end

  logic                out_valid_q;
  logic [OUT_DAT_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {{PadW{1'b0}}, value_q, gen_done_q,
                     COORD_W'(pos_row_q), COORD_W'(pos_col_q)};
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  logic req_in_store;

  assign req_in_store = (CmpW'(req_row_q) < CmpW'(MAX_DIM)) &&
                        (CmpW'(req_col_q) < CmpW'(MAX_DIM));

  always_comb begin
    sts_o.sweep_last = cnt_q == '1;
    sts_o.gen_done   = gen_done_q;
    sts_o.rd_ok      = init_q && req_in_store;
    sts_o.dirs_zero  = dirs_q == 4'd0;
    sts_o.hit        = dirs_q[d_new];
    sts_o.tgt_ok     = tgt_ok;
    sts_o.tgt_free   = (rdata_q.kind == KIND_OPEN) && !rdata_q.linked;
    sts_o.at_start   = (pos_col_q == CW'(1)) && (pos_row_q == CW'(1));
    sts_o.start_next = sts_o.at_start || ((par_col == CW'(1)) && (par_row == CW'(1)));
    sts_o.out_full   = out_valid_q;
  end

endmodule

// ===== rtl/core/mbg_ctrl.sv =====
// Controller state machine of the maze generator.
module mbg_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [mbg_pkg::OP_W-1:0]   in_op_i,
  output logic                       in_ready_o,
  input  mbg_pkg::sts_t              sts_i,
  input  logic                       m_ready_i,
  output mbg_pkg::cmd_t              cmd_o
);
  import mbg_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SWEEP    = 4'd1;
  localparam logic [3:0] S_RD_ISSUE = 4'd2;
  localparam logic [3:0] S_RD_WAIT  = 4'd3;
  localparam logic [3:0] S_CUR_WAIT = 4'd4;
  localparam logic [3:0] S_DRAW     = 4'd5;
  localparam logic [3:0] S_TGT_RD   = 4'd6;
  localparam logic [3:0] S_TGT_WAIT = 4'd7;
  localparam logic [3:0] S_MID      = 4'd8;
  localparam logic [3:0] S_ADVANCE  = 4'd9;
  localparam logic [3:0] S_BACK     = 4'd10;
  localparam logic [3:0] S_START_WR = 4'd11;
  localparam logic [3:0] S_RESULT   = 4'd12;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          unique case (in_op_i)
            OP_RESTART: state_d = S_SWEEP;
            OP_STEP: begin
              if (sts_i.gen_done) begin
                state_d = S_RESULT;
              end else begin
                cmd_o.rd_cur = 1'b1;
                state_d      = S_CUR_WAIT;
              end
            end
            OP_READ: state_d = S_RD_ISSUE;
            OP_NOP:  state_d = S_RESULT;
            default: state_d = S_RESULT;
          endcase
        end
      end
      S_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.start_walk = 1'b1;
          state_d          = S_RESULT;
        end
      end
      S_RD_ISSUE: begin
        if (sts_i.rd_ok) begin
          cmd_o.rd_req = 1'b1;
          state_d      = S_RD_WAIT;
        end else begin
          cmd_o.val_wall = 1'b1;
          state_d        = S_RESULT;
        end
      end
      S_RD_WAIT: begin
        cmd_o.val_mem = 1'b1;
        state_d       = S_RESULT;
      end
      S_CUR_WAIT: begin
        cmd_o.load_cur = 1'b1;
        state_d        = S_DRAW;
      end
      S_DRAW: begin
        if (sts_i.dirs_zero) begin
          state_d = S_BACK;
        end else begin
          cmd_o.draw = 1'b1;
          if (sts_i.hit && sts_i.tgt_ok) begin
            state_d = S_TGT_RD;
          end
        end
      end
      S_TGT_RD: begin
        cmd_o.rd_tgt = 1'b1;
        state_d      = S_TGT_WAIT;
      end
      S_TGT_WAIT: begin
        if (sts_i.tgt_free) begin
          cmd_o.wr_tgt = 1'b1;
          state_d      = S_MID;
        end else begin
          state_d = S_DRAW;
        end
      end
      S_MID: begin
        cmd_o.wr_mid = 1'b1;
        state_d      = S_ADVANCE;
      end
      S_ADVANCE: begin
        cmd_o.wr_cur   = 1'b1;
        cmd_o.move_tgt = 1'b1;
        state_d        = S_RESULT;
      end
      S_BACK: begin
        cmd_o.wr_cur      = 1'b1;
        cmd_o.move_parent = !sts_i.at_start;
        state_d           = sts_i.start_next ? S_START_WR : S_RESULT;
      end
      S_START_WR: begin
        cmd_o.wr_start = 1'b1;
        cmd_o.set_done = 1'b1;
        state_d        = S_RESULT;
      end
      S_RESULT: begin
        if (!sts_i.out_full || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
